@@ src/pcx_pkg.sv @@
// Shared types and constants for the PCX line decoder.
package pcx_pkg;
   localparam int MaxPlaneBytes = 1024;
   localparam int MaxPlanes = 4;
   localparam int TableEntries = 256;
   localparam int StoreDepth = MaxPlaneBytes * MaxPlanes;
   localparam int AddrW = $clog2(StoreDepth);
   localparam int PbW = $clog2(MaxPlaneBytes + 1);
   localparam int FillW = 13;
   localparam int ColW = 13;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_TABLE = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_MONO   = 2'd0,
      MODE_PLANAR = 2'd1,
      MODE_INDEX  = 2'd2,
      MODE_RGB    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_MODE   = 3'd0,
      REG_RLE    = 3'd1,
      REG_WIDTH  = 3'd2,
      REG_PLANE  = 3'd3,
      REG_HEIGHT = 3'd4
   } reg_type;

   // Command handed from the front part to the back part.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [7:0] table_index;
      logic [7:0] table_value;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_READ,
      ST_WAIT,
      ST_CALC,
      ST_EMIT
   } state_type;
endpackage

@@ src/pcx_cmd_queue.sv @@
// Short command queue between the front and back parts.
module pcx_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pcx_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output pcx_pkg::cmd_type pop_data,
   output logic             empty
);
   import pcx_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ (push && !full);
      rd_ptr_in = rd_ptr_ff ^ (pop && !empty);
      count_in = count_ff + {1'b0, push && !full} - {1'b0, pop && !empty};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

@@ src/pcx_front.sv @@
// Front part: configuration registers and intake of items.
module pcx_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic [1:0]       mode,
   output logic             rle_en,
   output logic [13:0]      width,
   output logic [10:0]      plane,
   output logic [15:0]      height,
   input  logic             req_push,
   output logic             req_full,
   input  logic [1:0]       req_kind,
   input  logic [7:0]       req_data_byte,
   input  logic [7:0]       req_table_index,
   input  logic [7:0]       req_table_value,
   output logic             q_push,
   output pcx_pkg::cmd_type q_data,
   input  logic             q_full
);
   import pcx_pkg::*;

   logic [1:0]  mode_ff;
   logic        rle_ff;
   logic [13:0] width_ff;
   logic [10:0] plane_ff;
   logic [15:0] height_ff;
   logic        wr_en;
   reg_type     reg_sel;

   assign reg_sel = reg_type'(csr_paddr[4:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 2'd2;
         rle_ff <= 1'b1;
         width_ff <= 14'd640;
         plane_ff <= 11'd640;
         height_ff <= 16'd480;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_MODE:   mode_ff <= csr_pwdata[1:0];
            REG_RLE:    rle_ff <= csr_pwdata[0];
            REG_WIDTH:  width_ff <= csr_pwdata[13:0];
            REG_PLANE:  plane_ff <= csr_pwdata[10:0];
            REG_HEIGHT: height_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (reg_sel)
         REG_MODE:   csr_prdata = {30'd0, mode_ff};
         REG_RLE:    csr_prdata = {31'd0, rle_ff};
         REG_WIDTH:  csr_prdata = {18'd0, width_ff};
         REG_PLANE:  csr_prdata = {21'd0, plane_ff};
         REG_HEIGHT: csr_prdata = {16'd0, height_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   assign mode = mode_ff;
   assign rle_en = rle_ff;
   assign width = width_ff;
   assign plane = plane_ff;
   assign height = height_ff;

   // Items pass straight into the queue; unknown kinds still occupy a slot.
   assign req_full = q_full;
   assign q_push = req_push;
   assign q_data = '{kind: kind_type'(req_kind), data_byte: req_data_byte,
                     table_index: req_table_index, table_value: req_table_value};
endmodule

@@ src/pcx_back.sv @@
// Back part: line store, gray table, run expansion and pixel drain.
module pcx_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       mode,
   input  logic             rle_en,
   input  logic [13:0]      width,
   input  logic [10:0]      plane,
   input  logic [15:0]      height,
   input  logic             q_empty,
   input  pcx_pkg::cmd_type q_data,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_gray_level,
   output logic             rsp_last_in_line,
   output logic             rsp_last_in_image,
   output logic             rsp_byte_refused
);
   import pcx_pkg::*;

   logic [7:0] store_mem [StoreDepth];
   logic [7:0] table_mem [TableEntries];

   state_type   state_ff, state_in;
   logic [FillW-1:0] fill_ff, fill_in;
   logic [6:0]  run_ff, run_in;
   logic        ready_ff, ready_in;
   logic [ColW-1:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [7:0]  rbyte_ff, rbyte_in;
   logic [1:0]  rd_ff, rd_in;
   logic [3:0]  bits_ff, bits_in;
   logic [17:0] acc_ff, acc_in;
   logic [7:0]  rd_data_ff;
   logic [7:0]  tab_data_ff;
   logic        tab_rd;
   logic [7:0]  tab_addr;
   logic        st_we;
   logic [AddrW-1:0] st_waddr, st_raddr;
   logic [7:0]  st_wdata;
   logic        ov_ff, ov_in;
   logic [7:0]  og_ff, og_in;
   logic        ol_ff, ol_in, oi_ff, oi_in, or_ff, or_in;
   logic        endl_ff, endl_in, endi_ff, endi_in;

   logic [PbW-1:0]  pb;
   logic [FillW:0]  total;
   logic [FillW:0]  cap;
   logic [13:0]     w_eff;
   logic [15:0]     h_eff;
   logic [7:0]      mask;
   logic [FillW:0]  base;
   logic [7:0]      coef;
   logic            bitv;

   // Effective sizes from configuration.
   always_comb begin
      if (plane == 11'd0) pb = PbW'(1);
      else if ({21'd0, plane} > 32'(MaxPlaneBytes)) pb = PbW'(MaxPlaneBytes);
      else pb = PbW'(plane);
      unique case (mode_type'(mode))
         MODE_MONO:   total = (FillW+1)'(pb);
         MODE_PLANAR: total = (FillW+1)'({pb, 2'b00});
         MODE_INDEX:  total = (FillW+1)'(pb);
         default:     total = (FillW+1)'(pb) + (FillW+1)'({pb, 1'b0});
      endcase
      cap = (mode[1] == 1'b0) ? (FillW+1)'({pb, 3'b000}) : (FillW+1)'(pb);
      if (width == 14'd0) w_eff = 14'd1;
      else if ((FillW+1)'(width) > cap) w_eff = 14'(cap);
      else w_eff = width;
      h_eff = (height == 16'd0) ? 16'd1 : height;
      mask = 8'h80 >> col_ff[2:0];
      bitv = |(rd_data_ff & mask);
   end

   // Store address of plane rd_ff for the current column.
   always_comb begin
      if (mode[1] == 1'b0) base = (FillW+1)'(col_ff >> 3);
      else base = (FillW+1)'(col_ff);
      unique case (rd_ff)
         2'd0: st_raddr = AddrW'(base);
         2'd1: st_raddr = AddrW'(base + (FillW+1)'(pb));
         2'd2: st_raddr = AddrW'(base + (FillW+1)'({pb, 1'b0}));
         default: st_raddr = AddrW'(base + (FillW+1)'(pb) + (FillW+1)'({pb, 1'b0}));
      endcase
      unique case (rd_ff)
         2'd1:    coef = 8'd151;
         2'd2:    coef = 8'd28;
         default: coef = 8'd77;
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      run_in = run_ff;
      ready_in = ready_ff;
      col_in = col_ff;
      row_in = row_ff;
      cnt_in = cnt_ff;
      rbyte_in = rbyte_ff;
      rd_in = rd_ff;
      bits_in = bits_ff;
      acc_in = acc_ff;
      ov_in = ov_ff && !rsp_pop;
      og_in = og_ff;
      ol_in = ol_ff;
      oi_in = oi_ff;
      or_in = or_ff;
      endl_in = endl_ff;
      endi_in = endi_ff;
      q_pop = 1'b0;
      st_we = 1'b0;
      st_waddr = AddrW'(fill_ff);
      st_wdata = q_data.data_byte;
      tab_rd = 1'b0;
      tab_addr = 8'd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty && !ov_in) begin
               q_pop = 1'b1;
               unique case (q_data.kind)
                  KIND_BYTE: begin
                     if (ready_ff) begin
                        ov_in = 1'b1;
                        og_in = 8'd0;
                        ol_in = 1'b0;
                        oi_in = 1'b0;
                        or_in = 1'b1;
                     end else if (rle_en && run_ff[6]) begin
                        run_in = 7'd0;
                        cnt_in = run_ff[5:0];
                        rbyte_in = q_data.data_byte;
                        state_in = ST_RUN;
                     end else if (rle_en && q_data.data_byte >= 8'hC0) begin
                        run_in = {1'b1, q_data.data_byte[5:0]};
                     end else begin
                        run_in = 7'd0;
                        st_we = 1'b1;
                        fill_in = fill_ff + 1'b1;
                        if ((FillW+1)'(fill_in) >= total) begin
                           ready_in = 1'b1;
                           col_in = '0;
                        end
                     end
                  end
                  KIND_TABLE: ;
                  KIND_TICK: begin
                     if (ready_ff) begin
                        rd_in = 2'd0;
                        bits_in = 4'd0;
                        acc_in = 18'd0;
                        state_in = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // One byte of the run per cycle, clipped at the line end.
         ST_RUN: begin
            if (cnt_ff != 6'd0 && (FillW+1)'(fill_ff) < total) begin
               st_we = 1'b1;
               st_wdata = rbyte_ff;
               fill_in = fill_ff + 1'b1;
               cnt_in = cnt_ff - 1'b1;
            end else begin
               if ((FillW+1)'(fill_ff) >= total) begin
                  ready_in = 1'b1;
                  col_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         // Issue a store read for the current plane.
         ST_READ: state_in = ST_WAIT;
         ST_WAIT: state_in = ST_CALC;
         // Fold one plane's byte into the pixel.
         ST_CALC: begin
            if (mode_type'(mode) == MODE_RGB) begin
               acc_in = acc_ff + 18'(rd_data_ff) * 18'(coef);
            end
            bits_in = bits_ff | (4'(bitv) << rd_ff);
            if ((mode_type'(mode) == MODE_PLANAR && rd_ff != 2'd3) ||
                (mode_type'(mode) == MODE_RGB && rd_ff != 2'd2)) begin
               rd_in = rd_ff + 1'b1;
               state_in = ST_READ;
            end else begin
               tab_rd = 1'b1;
               unique case (mode_type'(mode))
                  MODE_MONO:   tab_addr = {7'd0, bitv};
                  MODE_PLANAR: tab_addr = {4'd0, bits_in};
                  default:     tab_addr = rd_data_ff;
               endcase
               endl_in = (14'(col_ff) + 14'd1 >= w_eff) || (col_ff == '1);
               endi_in = 17'(row_ff) + 17'd1 >= 17'(h_eff);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!ov_in) begin
               ov_in = 1'b1;
               og_in = (mode_type'(mode) == MODE_RGB) ? acc_ff[15:8] : tab_data_ff;
               ol_in = endl_ff;
               oi_in = endl_ff && endi_ff;
               or_in = 1'b0;
               col_in = col_ff + 1'b1;
               if (endl_ff) begin
                  ready_in = 1'b0;
                  fill_in = '0;
                  col_in = '0;
                  row_in = endi_ff ? 16'd0 : row_ff + 16'd1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         run_ff <= 7'd0;
         ready_ff <= 1'b0;
         col_ff <= '0;
         row_ff <= 16'd0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         run_ff <= run_in;
         ready_ff <= ready_in;
         col_ff <= col_in;
         row_ff <= row_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rbyte_ff <= rbyte_in;
      rd_ff <= rd_in;
      bits_ff <= bits_in;
      acc_ff <= acc_in;
      og_ff <= og_in;
      ol_ff <= ol_in;
      oi_ff <= oi_in;
      or_ff <= or_in;
      endl_ff <= endl_in;
      endi_ff <= endi_in;
   end

   // Line store memory.
   always_ff @(posedge clock) begin
      if (st_we) store_mem[st_waddr] <= st_wdata;
      rd_data_ff <= store_mem[st_raddr];
   end

   // Gray table memory.
   always_ff @(posedge clock) begin
      if (q_pop && q_data.kind == KIND_TABLE) begin
         table_mem[q_data.table_index] <= q_data.table_value;
      end
      if (tab_rd) tab_data_ff <= table_mem[tab_addr];
   end

   assign rsp_empty = !ov_ff;
   assign rsp_gray_level = og_ff;
   assign rsp_last_in_line = ol_ff;
   assign rsp_last_in_image = oi_ff;
   assign rsp_byte_refused = or_ff;
endmodule

@@ src/pcx_line_decoder_to_gray.sv @@
// Top level of the PCX line decoder to gray levels.
// Usage:
//    Items enter through a queue-like port: req_push with req_full, fields
//    req_kind, req_data_byte, req_table_index and req_table_value.
//    Results leave through rsp_empty and rsp_pop; the oldest result stays on
//    the rsp_ ports while rsp_empty is low.
//    Configuration goes through the APB-style csr_ port, one register per
//    word address; write only while the block is idle.
// Sequencing:
//    A two-entry queue parts intake from the sequencer. A literal byte or a
//    table write is handled in the idle state; a run is written out byte by
//    byte. A tick reads the line store once per plane (1 plane for mono and
//    indexed, 3 for RGB, 4 for planar) through the read, wait and calc
//    states, then emits its result from the emit state.
// Reset:
//    Synchronous reset empties the queue and the result register and loads
//    the register defaults; the line store and gray table are not cleared.
// Stalls:
//    When the result is not popped the sequencer waits, the queue fills and
//    req_full rises.
module pcx_line_decoder_to_gray (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_table_index,
   input  logic [7:0]  req_table_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_gray_level,
   output logic        rsp_last_in_line,
   output logic        rsp_last_in_image,
   output logic        rsp_byte_refused
);
   import pcx_pkg::*;

   logic [1:0]  mode;
   logic        rle_en;
   logic [13:0] width;
   logic [10:0] plane;
   logic [15:0] height;
   logic        q_push, q_full, q_pop, q_empty;
   cmd_type     q_in, q_out;

   assign csr_pready = 1'b1;

   pcx_front u_front (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .mode, .rle_en, .width, .plane, .height,
      .req_push, .req_full, .req_kind, .req_data_byte, .req_table_index,
      .req_table_value, .q_push, .q_data(q_in), .q_full
   );

   pcx_cmd_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .pop_data(q_out), .empty(q_empty)
   );

   pcx_back u_back (
      .clock, .reset, .mode, .rle_en, .width, .plane, .height, .q_empty,
      .q_data(q_out), .q_pop, .rsp_empty, .rsp_pop, .rsp_gray_level,
      .rsp_last_in_line, .rsp_last_in_image, .rsp_byte_refused
   );
endmodule
